>>> hw/rtl/four_level_page_table_walker_defines.svh
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Concurrent assertion helpers clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define PTW_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("page table walker assertion failed");
`define PTW_ASSERT_IMPLY(label, cond, prop) \
    `PTW_ASSERT(label, (cond) |-> (prop))
`else
`define PTW_ASSERT(label, prop)
`define PTW_ASSERT_IMPLY(label, cond, prop)
`endif
`endif

>>> hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Item types, field codes and the per-level index select.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int LIN_W  = 48;
    localparam int PHYS_W = 59;
    localparam int ENTRY_W = 64;
    localparam int PA_W   = 64;
    localparam int IDX_W  = 9;

    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [1:0] PAGE_4K = 2'd0;
    localparam logic [1:0] PAGE_2M = 2'd1;
    localparam logic [1:0] PAGE_1G = 2'd2;

    localparam logic [1:0] LEVEL_TOP  = 2'd0;
    localparam logic [1:0] LEVEL_DIR1 = 2'd1;
    localparam logic [1:0] LEVEL_DIR2 = 2'd2;
    localparam logic [1:0] LEVEL_LAST = 2'd3;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef struct packed {
        logic              mode;
        logic [LIN_W-1:0]  linear_address;
        logic [ENTRY_W-1:0] entry_data;
    } ptw_in_t;

    typedef struct packed {
        logic              kind;
        logic [PHYS_W-1:0] read_address;
        logic [PA_W-1:0]   physical_address;
        logic              fault;
        logic [1:0]        page_size;
    } ptw_out_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] level;
    } ptw_status_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [LIN_W-1:0] lin,
                                                     input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        unique case (level)
            LEVEL_TOP:  idx = lin[47:39];
            LEVEL_DIR1: idx = lin[38:30];
            LEVEL_DIR2: idx = lin[29:21];
            LEVEL_LAST: idx = lin[20:12];
            default:    idx = '0;
        endcase
        return idx;
    endfunction

endpackage

>>> hw/rtl/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// Four-level page table walker
// Translates 48-bit linear addresses through four levels of page tables.
// ----------------------------------------------------------------------------
// The walker takes one item per clock cycle unless an untaken result stalls
// it. A result, if any, passes the input register, then the walk decision,
// then the result register. A translate item yields a read request for the
// top-level entry; each response item yields either the next read request or
// the finished translation. Responses that arrive while no walk is open
// produce no result. The user must write the root table base through the
// configuration channel only while the walker is idle; this is not enforced.
`include "four_level_page_table_walker_defines.svh"

module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PHYS_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptw_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ptw_out_t          m_data
);

    logic [PHYS_W-1:0] root_reg;
    logic              in_valid_reg;
    ptw_in_t           in_data_reg;
    logic              out_valid_reg;
    ptw_out_t          out_data_reg;
    logic              advance;
    ptw_out_t          step_result;
    logic              step_has_result;
    ptw_status_t       status;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            root_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    ptw_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_data_reg),
        .table_root (root_reg),
        .result     (step_result),
        .has_result (step_has_result),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_has_result;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_has_result) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `PTW_ASSERT_IMPLY(a_idle_level_top, !status.busy, status.level == LEVEL_TOP)
    `PTW_ASSERT_IMPLY(a_request_fields_clear, m_valid && m_data.kind == KIND_REQUEST,
        !m_data.fault && m_data.physical_address == '0 && m_data.page_size == PAGE_4K)
    `PTW_ASSERT_IMPLY(a_done_no_address, m_valid && m_data.kind == KIND_DONE,
        m_data.read_address == '0)
    `PTW_ASSERT_IMPLY(a_fault_all_ones, m_valid && m_data.fault,
        m_data.physical_address == '1 && m_data.page_size == PAGE_4K)
    `PTW_ASSERT_IMPLY(a_start_opens_walk, advance && in_data_reg.mode == MODE_START,
        ##1 status.busy && status.level == LEVEL_TOP)

endmodule

>>> hw/rtl/ptw_walk.sv
// ----------------------------------------------------------------------------
// Page table walker step logic
// Walk state registers and the combinational decision for one item.
// ----------------------------------------------------------------------------
module ptw_walk
    import ptw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ptw_in_t           item,
    input  logic [PHYS_W-1:0] table_root,
    output ptw_out_t          result,
    output logic              has_result,
    output ptw_status_t       status
);

    logic             busy_reg, busy_next;
    logic [1:0]       level_reg, level_next;
    logic [LIN_W-1:0] held_reg, held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= LEVEL_TOP;
            held_reg  <= '0;
        end else if (step_en) begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            held_reg  <= held_next;
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        level_next = level_reg;
        held_next  = held_reg;
        has_result = 1'b0;
        result     = '0;
        if (item.mode == MODE_START) begin
            held_next           = item.linear_address;
            level_next          = LEVEL_TOP;
            busy_next           = 1'b1;
            has_result          = 1'b1;
            result.kind         = KIND_REQUEST;
            result.read_address = {table_root[58:12],
                                   level_index(item.linear_address, LEVEL_TOP), 3'b000};
        end else if (busy_reg) begin
            has_result  = 1'b1;
            busy_next   = 1'b0;
            level_next  = LEVEL_TOP;
            result.kind = KIND_DONE;
            if (!item.entry_data[PRESENT_BIT]) begin
                result.physical_address = '1;
                result.fault            = 1'b1;
            end else if (level_reg == LEVEL_DIR1 && item.entry_data[LARGE_BIT]) begin
                result.physical_address = {5'b0, item.entry_data[58:30], held_reg[29:0]};
                result.page_size        = PAGE_1G;
            end else if (level_reg == LEVEL_DIR2 && item.entry_data[LARGE_BIT]) begin
                result.physical_address = {5'b0, item.entry_data[58:21], held_reg[20:0]};
                result.page_size        = PAGE_2M;
            end else if (level_reg == LEVEL_LAST) begin
                result.physical_address = {5'b0, item.entry_data[58:12], held_reg[11:0]};
                result.page_size        = PAGE_4K;
            end else begin
                busy_next           = 1'b1;
                level_next          = level_reg + 2'd1;
                result.kind         = KIND_REQUEST;
                result.read_address = {item.entry_data[58:12],
                                       level_index(held_reg, level_next), 3'b000};
            end
        end
    end

    assign status.busy  = busy_reg;
    assign status.level = level_reg;

endmodule

>>> test/four_level_page_table_walker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker checker
// Watches the configuration, translate/response and result channels, keeps
// its own copy of the walk state and the root base, and compares every
// accepted result, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_checker
    import ptw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [PHYS_W-1:0] cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ptw_in_t           s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ptw_out_t          m_data,
    output int                fail_count,
    output int                outstanding
);

    localparam logic [63:0] TABLE_MASK = 64'h07FF_FFFF_FFFF_F000;
    localparam logic [63:0] MASK_1G    = 64'h0000_0000_3FFF_FFFF;
    localparam logic [63:0] MASK_2M    = 64'h0000_0000_001F_FFFF;

    logic [PHYS_W-1:0] table_root;
    logic              walk_open;
    logic [1:0]        walk_level;
    logic [LIN_W-1:0]  held_lin;
    ptw_out_t          due_results[$];

    function automatic logic [PHYS_W-1:0] entry_offset(input logic [LIN_W-1:0] lin,
                                                       input logic [1:0] lvl);
        logic [LIN_W-1:0] shifted;
        shifted = lin >> (39 - 9 * int'(lvl));
        return PHYS_W'({shifted[8:0], 3'b000});
    endfunction

    // Advances the walk by one item; returns 1 when the item yields a result.
    function automatic bit next_walk_output(input ptw_in_t item, output ptw_out_t res);
        logic [63:0] base;
        res = '0;
        if (item.mode == MODE_START) begin
            held_lin   = item.linear_address;
            walk_level = LEVEL_TOP;
            walk_open  = 1'b1;
            res.kind   = KIND_REQUEST;
            res.read_address = {table_root[PHYS_W-1:12], 12'h000}
                               + entry_offset(held_lin, LEVEL_TOP);
            return 1'b1;
        end
        if (!walk_open) begin
            return 1'b0;
        end
        base = item.entry_data & TABLE_MASK;
        res.kind = KIND_DONE;
        if (!item.entry_data[PRESENT_BIT]) begin
            walk_open = 1'b0;
            walk_level = LEVEL_TOP;
            res.physical_address = '1;
            res.fault = 1'b1;
        end else if (item.entry_data[LARGE_BIT] && walk_level == LEVEL_DIR1) begin
            walk_open = 1'b0;
            walk_level = LEVEL_TOP;
            res.physical_address = (base & ~MASK_1G) + ({16'h0, held_lin} & MASK_1G);
            res.page_size = PAGE_1G;
        end else if (item.entry_data[LARGE_BIT] && walk_level == LEVEL_DIR2) begin
            walk_open = 1'b0;
            walk_level = LEVEL_TOP;
            res.physical_address = (base & ~MASK_2M) + ({16'h0, held_lin} & MASK_2M);
            res.page_size = PAGE_2M;
        end else if (walk_level == LEVEL_LAST) begin
            walk_open = 1'b0;
            walk_level = LEVEL_TOP;
            res.physical_address = base + {52'h0, held_lin[11:0]};
            res.page_size = PAGE_4K;
        end else begin
            walk_level = walk_level + 2'd1;
            res.kind = KIND_REQUEST;
            res.read_address = base[PHYS_W-1:0] + entry_offset(held_lin, walk_level);
        end
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        ptw_out_t want;
        ptw_out_t predicted;
        if (!aresetn) begin
            table_root = '0;
            walk_open  = 1'b0;
            walk_level = LEVEL_TOP;
            held_lin   = '0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("kind", 64'(want.kind), 64'(m_data.kind));
                    compare_field("read_address", 64'(want.read_address),
                                  64'(m_data.read_address));
                    compare_field("physical_address", want.physical_address,
                                  m_data.physical_address);
                    compare_field("fault", 64'(want.fault), 64'(m_data.fault));
                    compare_field("page_size", 64'(want.page_size),
                                  64'(m_data.page_size));
                end
            end
            if (cfg_valid && cfg_ready) begin
                table_root = cfg_data;
            end
            if (s_valid && s_ready && next_walk_output(s_data, predicted)) begin
                due_results.push_back(predicted);
            end
        end
        outstanding = due_results.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker testbench
// Drives translate and response items through the walker with random gaps
// on both channels, rewrites the root base between phases, and leaves result
// checking to the checker module beside the walker.
// ----------------------------------------------------------------------------
module testbench
    import ptw_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [PHYS_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    ptw_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    ptw_out_t          m_data;
    int                fail_count;
    int                outstanding;
    int                items_sent;
    int                quiet_cycles;
    bit                steady;

    four_level_page_table_walker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    four_level_page_table_walker_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand_entry();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [LIN_W-1:0] rand_lin();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0: r = '0;
            1: r = '1;
            default: ;
        endcase
        return r[LIN_W-1:0];
    endfunction

    task automatic send(input ptw_in_t item);
        while (!steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic start_walk(input logic [LIN_W-1:0] lin);
        ptw_in_t item;
        item.mode = MODE_START;
        item.linear_address = lin;
        item.entry_data = rand_entry();
        send(item);
    endtask

    task automatic answer(input logic [63:0] entry);
        ptw_in_t item;
        item.mode = MODE_RESPONSE;
        item.linear_address = rand_lin();
        item.entry_data = entry;
        send(item);
    endtask

    // Closes any open walk with a non-present entry, lets the walker drain,
    // then writes the new root base.
    task automatic set_root(input logic [PHYS_W-1:0] root);
        logic [63:0] closer;
        closer = rand_entry();
        closer[PRESENT_BIT] = 1'b0;
        answer(closer);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= root;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_walk();
        logic [63:0] entry;
        int lvl;
        bit done;
        start_walk(rand_lin());
        done = 1'b0;
        for (lvl = 0; lvl < 4 && !done; lvl++) begin
            // Occasionally leave the walk open so the next translate restarts it.
            if ($urandom_range(99) < 4) begin
                return;
            end
            entry = rand_entry();
            entry[PRESENT_BIT] = ($urandom_range(99) >= 8);
            entry[LARGE_BIT] = ($urandom_range(99) < 25);
            answer(entry);
            done = !entry[PRESENT_BIT] || (entry[LARGE_BIT] && (lvl == 1 || lvl == 2));
        end
        if ($urandom_range(99) < 5) begin
            answer(rand_entry());
        end
    endtask

    task automatic random_phase(input int target);
        while (items_sent < target) begin
            random_walk();
        end
    endtask

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        steady     = 1'b0;
        items_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        set_root('0);

        answer('1);
        start_walk('0);
        answer(64'h0000_0000_0000_0081);
        answer(64'h07FF_FFFF_FFFF_F001);
        answer(64'h0000_0000_0000_1001);
        answer('1);
        start_walk('1);
        answer('1);
        answer('1);
        start_walk('1);
        answer(64'h8000_0000_0000_0001);
        answer(64'h7FFF_FFFF_FFFF_FF7F);
        answer('1);
        start_walk(48'h8000_4020_1000);
        answer('0);
        start_walk(48'h0000_7FE0_3FF0);
        answer(64'h0000_0000_0000_0001);
        answer(64'hFFFF_FFFF_FFFF_FFFE);
        start_walk(rand_lin());
        answer(64'h0000_0000_0000_0001);
        start_walk(48'h1234_5678_9ABC);
        answer(64'h0000_0000_0000_0001);
        answer(64'h0000_0000_0000_0001);
        answer(64'h0000_0000_0000_0001);
        answer(64'h0000_0000_0000_0080);

        set_root('1);
        random_phase(420);
        set_root(PHYS_W'({$urandom, $urandom}));
        steady = 1'b1;
        random_phase(800);
        steady = 1'b0;
        set_root(59'h7FF_FFFF_FFFF_F000);
        random_phase(1200);
        set_root(PHYS_W'({$urandom, $urandom}));
        random_phase(1550);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
